// ----- rtl/core/slpr_pkg.sv -----
// ----------------------------------------------------------------------------
// slpr_pkg: shared definitions for the slew-limited PID step-rate core
// Widths, reset values, register indexes and the structs passed between the
// filter, the limiter and the top level.
// ----------------------------------------------------------------------------
package slpr_pkg;

    localparam int ANGLE_FRAC_BITS = 8;
    localparam int COEF_FRAC_BITS  = 16;
    localparam int RATE_BITS       = 12;

    localparam int ANGLE_W = 19;
    localparam int COEF_W  = 32;
    localparam int CMD_W   = 21;
    localparam int ERR_W   = ANGLE_W + 1;

    // Products and the exact sum of five of them.
    localparam int PROD_E_W = COEF_W + ERR_W;
    localparam int PROD_U_W = COEF_W + CMD_W;
    localparam int ACC_W    = PROD_U_W + 3;
    localparam int U_W      = ACC_W - COEF_FRAC_BITS;

    // Magnitude limits in command units: (rate) << ANGLE_FRAC_BITS.
    localparam int LIM_W = RATE_BITS + 1 + ANGLE_FRAC_BITS;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_W;

    localparam int IN_TDATA_W  = ((2 * ANGLE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((RATE_BITS + CMD_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_B0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT = 3'd6;

    localparam logic signed [COEF_W-1:0] RST_COEF_B0 = 32'sd215613440;   //  3290.0
    localparam logic signed [COEF_W-1:0] RST_COEF_B1 = -32'sd207290368;  // -3163.0
    localparam logic signed [COEF_W-1:0] RST_COEF_B2 = '0;
    localparam logic signed [COEF_W-1:0] RST_COEF_A1 = -32'sd65536;      // -1.0
    localparam logic signed [COEF_W-1:0] RST_COEF_A2 = '0;
    localparam logic [RATE_BITS-1:0]     RST_ACCEL_STEP = 12'd5;
    localparam logic [RATE_BITS-1:0]     RST_RATE_LIMIT = 12'd1500;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } t_coefs;

    typedef struct packed {
        logic [RATE_BITS-1:0]    step_rate;
        logic                    reverse;
        logic signed [CMD_W-1:0] command;
    } t_result;

endpackage

// ----- rtl/core/slpr_filter.sv -----
// ----------------------------------------------------------------------------
// slpr_filter: second-order difference equation
// Forms u = b0*e0 + b1*e1 + b2*e2 - a1*u1 - a2*u2 exactly and drops the
// coefficient fraction bits, rounding toward minus infinity.
// ----------------------------------------------------------------------------
module slpr_filter (
    input  slpr_pkg::t_coefs                     i_coefs,
    input  logic signed [slpr_pkg::ERR_W-1:0]    i_err0,
    input  logic signed [slpr_pkg::ERR_W-1:0]    i_err1,
    input  logic signed [slpr_pkg::ERR_W-1:0]    i_err2,
    input  logic signed [slpr_pkg::CMD_W-1:0]    i_cmd1,
    input  logic signed [slpr_pkg::CMD_W-1:0]    i_cmd2,
    output logic signed [slpr_pkg::U_W-1:0]      o_u
);
    import slpr_pkg::*;

    logic signed [PROD_E_W-1:0] prod_b0;
    logic signed [PROD_E_W-1:0] prod_b1;
    logic signed [PROD_E_W-1:0] prod_b2;
    logic signed [PROD_U_W-1:0] prod_a1;
    logic signed [PROD_U_W-1:0] prod_a2;
    logic signed [ACC_W-1:0]    acc;

    assign prod_b0 = i_coefs.b0 * i_err0;
    assign prod_b1 = i_coefs.b1 * i_err1;
    assign prod_b2 = i_coefs.b2 * i_err2;
    assign prod_a1 = i_coefs.a1 * i_cmd1;
    assign prod_a2 = i_coefs.a2 * i_cmd2;

    assign acc = ACC_W'(prod_b0) + ACC_W'(prod_b1) + ACC_W'(prod_b2)
               - ACC_W'(prod_a1) - ACC_W'(prod_a2);

    // Dropping the low bits of a two's complement value is a floor.
    assign o_u = acc[ACC_W-1:COEF_FRAC_BITS];

endmodule

// ----- rtl/core/slpr_limit.sv -----
// ----------------------------------------------------------------------------
// slpr_limit: slew and saturation limiter
// Caps the magnitude of the raw command at the smaller of the slew bound and
// the absolute limit, keeping its sign, and derives step rate and direction.
// ----------------------------------------------------------------------------
module slpr_limit (
    input  logic signed [slpr_pkg::U_W-1:0]      i_u,
    input  logic [slpr_pkg::RATE_BITS-1:0]       i_last_rate,
    input  logic [slpr_pkg::RATE_BITS-1:0]       i_accel_step,
    input  logic [slpr_pkg::RATE_BITS-1:0]       i_rate_limit,
    output slpr_pkg::t_result                    o_result
);
    import slpr_pkg::*;

    logic [RATE_BITS:0]      rate_sum;
    logic [LIM_W-1:0]        slew_lim;
    logic [LIM_W-1:0]        sat_lim;
    logic [LIM_W-1:0]        cap;
    logic                    u_neg;
    logic [U_W-1:0]          u_mag;
    logic signed [CMD_W-1:0] cap_cmd;
    logic signed [CMD_W-1:0] cmd;
    logic [CMD_W-1:0]        cmd_mag;
    logic [RATE_BITS-1:0]    rate;

    assign rate_sum = {1'b0, i_last_rate} + {1'b0, i_accel_step};
    assign slew_lim = {rate_sum, ANGLE_FRAC_BITS'(0)};
    assign sat_lim  = {1'b0, i_rate_limit, ANGLE_FRAC_BITS'(0)};

    // Slew clamp followed by the absolute clamp equals one clamp at the
    // smaller bound, with zero counted as positive.
    assign cap = (slew_lim < sat_lim) ? slew_lim : sat_lim;

    assign u_neg   = i_u[U_W-1];
    assign u_mag   = u_neg ? U_W'(-i_u) : U_W'(i_u);
    assign cap_cmd = CMD_W'(cap);

    always_comb begin
        if (u_mag > U_W'(cap)) begin
            cmd = u_neg ? -cap_cmd : cap_cmd;
        end else begin
            cmd = CMD_W'(i_u);
        end
    end

    assign cmd_mag = cmd[CMD_W-1] ? CMD_W'(-cmd) : CMD_W'(cmd);
    assign rate    = cmd_mag[ANGLE_FRAC_BITS +: RATE_BITS];

    assign o_result.step_rate = rate;
    assign o_result.reverse   = cmd[CMD_W-1] && (rate != '0);
    assign o_result.command   = cmd;

endmodule

// ----- rtl/core/slew_limited_pid_step_rate_core.sv -----
// ----------------------------------------------------------------------------
// slew_limited_pid_step_rate_core: PID step-rate controller with slew limit
// One control tick per request: error, difference-equation filter, slew and
// saturation limiting, step rate and direction.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid/tready       tdata: target_angle, measured_angle
// m_axis    out        m_axis_tvalid/tready       tdata: step_rate, command;
//                                                 tuser: reverse
// cfg       in         i_cfg_valid/o_cfg_ready    i_cfg_index, i_cfg_data
//
// A request waits in the input register and then moves into the output
// register; one request is taken every cycle unless the sink holds the
// output register. The bound is the single pass through five multipliers,
// the five-term sum and the limiter, which also closes the feedback of the
// previous command and step rate. Reset (synchronous, active low) empties both
// registers, clears the histories and loads the default coefficients. When the
// output register is held by the sink, the input register keeps its request
// and the history is not advanced until that request moves on.
//
module slew_limited_pid_step_rate_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // bits from 0: target_angle[18:0], measured_angle[37:19], zero pad
    input  logic [slpr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // bits from 0: step_rate[11:0], command[32:12], zero pad
    output logic [slpr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // bits from 0: reverse[0]
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [slpr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [slpr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import slpr_pkg::*;

    // Configuration registers.
    t_coefs               r_coefs;
    logic [RATE_BITS-1:0] r_accel_step;
    logic [RATE_BITS-1:0] r_rate_limit;

    // Input register holds the error of the pending request.
    logic                    r_in_valid;
    logic signed [ERR_W-1:0] r_err0;

    // Controller history.
    logic signed [ERR_W-1:0] r_err1;
    logic signed [ERR_W-1:0] r_err2;
    logic signed [CMD_W-1:0] r_cmd1;
    logic signed [CMD_W-1:0] r_cmd2;
    logic [RATE_BITS-1:0]    r_last_rate;

    // Output register.
    logic    r_out_valid;
    t_result r_out;

    logic signed [ANGLE_W-1:0] in_target;
    logic signed [ANGLE_W-1:0] in_measured;
    logic signed [ERR_W-1:0]   n_err0;
    logic                      in_take;
    logic                      advance;
    logic signed [U_W-1:0]     u_raw;
    t_result                   n_result;

    assign in_target   = s_axis_tdata[ANGLE_W-1:0];
    assign in_measured = s_axis_tdata[2*ANGLE_W-1:ANGLE_W];
    assign n_err0      = ERR_W'(in_target) - ERR_W'(in_measured);

    // The pending request moves on whenever the output register is free or
    // being emptied in this cycle; a new request can enter behind it.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0   <= RST_COEF_B0;
            r_coefs.b1   <= RST_COEF_B1;
            r_coefs.b2   <= RST_COEF_B2;
            r_coefs.a1   <= RST_COEF_A1;
            r_coefs.a2   <= RST_COEF_A2;
            r_accel_step <= RST_ACCEL_STEP;
            r_rate_limit <= RST_RATE_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COEF_B0:    r_coefs.b0   <= i_cfg_data;
                REG_COEF_B1:    r_coefs.b1   <= i_cfg_data;
                REG_COEF_B2:    r_coefs.b2   <= i_cfg_data;
                REG_COEF_A1:    r_coefs.a1   <= i_cfg_data;
                REG_COEF_A2:    r_coefs.a2   <= i_cfg_data;
                REG_ACCEL_STEP: r_accel_step <= i_cfg_data[RATE_BITS-1:0];
                REG_RATE_LIMIT: r_rate_limit <= i_cfg_data[RATE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_err0 <= n_err0;
        end
    end

    // History advances exactly once per request, when it leaves the input
    // register, so a stalled request is never counted twice.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err1      <= '0;
            r_err2      <= '0;
            r_cmd1      <= '0;
            r_cmd2      <= '0;
            r_last_rate <= '0;
        end else if (advance) begin
            r_err2      <= r_err1;
            r_err1      <= r_err0;
            r_cmd2      <= r_cmd1;
            r_cmd1      <= n_result.command;
            r_last_rate <= n_result.step_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_result;
        end
    end

    slpr_filter u_filter (
        .i_coefs (r_coefs),
        .i_err0  (r_err0),
        .i_err1  (r_err1),
        .i_err2  (r_err2),
        .i_cmd1  (r_cmd1),
        .i_cmd2  (r_cmd2),
        .o_u     (u_raw)
    );

    slpr_limit u_limit (
        .i_u          (u_raw),
        .i_last_rate  (r_last_rate),
        .i_accel_step (r_accel_step),
        .i_rate_limit (r_rate_limit),
        .o_result     (n_result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.reverse;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out.command, r_out.step_rate});

endmodule
